>>> rtl/lmpc_pkg.sv
// Shared types and constants for the LED mode / PWM controller.
// No dependencies; imported by the controller top level.
package lmpc_pkg;

	localparam int NUM_KEYS = 4;

	localparam int TIME_W  = 16;
	localparam int LEVEL_W = 3;
	localparam int PCT_W   = 7;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	// compare = (period * percent) / 100 by reciprocal: exact for products below 2^23
	localparam int PROD_W      = TIME_W + 1 + PCT_W;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

	localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BEEP        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BREATHE_STEP = 3'd4;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_PRESS = 1'b1;

	localparam logic [1:0] KEY_MODE   = 2'd0;
	localparam logic [1:0] KEY_BRIGHT = 2'd1;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd4;
	localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
	localparam logic [TIME_W-1:0]  TIME_SAT  = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_ON      = 2'd1,
		MODE_BLINK   = 2'd2,
		MODE_BREATHE = 2'd3
	} mode_t;

	typedef struct packed {
		logic       action;
		logic [1:0] key_id;
	} cmd_t;

	typedef struct packed {
		logic [15:0] led_compare;
		logic [15:0] buzzer_compare;
		logic [1:0]  lamp_mode;
		logic [2:0]  bright_level;
	} res_t;

	function automatic logic [PCT_W-1:0] level_pct(input logic [LEVEL_W-1:0] level);
		logic [1:0] idx;
		idx = 2'(level - 3'd1);
		case (idx)
			2'd0:    level_pct = 7'd25;
			2'd1:    level_pct = 7'd50;
			2'd2:    level_pct = 7'd75;
			default: level_pct = 7'd100;
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
		sat_inc = (v == TIME_SAT) ? TIME_SAT : v + 16'd1;
	endfunction

	function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
		at_least_one = (v == '0) ? 16'd1 : v;
	endfunction

endpackage

>>> rtl/led_mode_pwm_controller.sv
// LED mode / brightness controller with key debounce, key beep and PWM compare output.
// Uses lmpc_pkg for the word types, mode codes, register indexes and helpers.
//
// One result word per command word, one command per clock sustained while res_stall does
// not hold the output. A command is registered on entry (stage 1); the mode/beep/blink/breathe
// state is updated from it as it moves on to stage 2, then the compare passes through two
// multiplier stages (period times percent into stage 3, then a reciprocal of 100 into stage 4),
// and the four-stage pipeline keeps taking words while a finished result waits under res_stall,
// until every stage holds a word.
// Registers are written through the plain cfg port and should only change while no
// word is in flight.
module led_mode_pwm_controller
	import lmpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef struct packed {
		logic             buzz;
		mode_t            mode;
		logic [LEVEL_W-1:0] level;
	} info_t;

	// configuration
	logic [TIME_W-1:0] pwm_top_q, debounce_q, beep_q, blink_half_q, breathe_step_q;

	// controller state
	mode_t              mode_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]  key_age_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] key_seen_q;
	logic [TIME_W-1:0]  beep_left_q;
	logic               buzzer_on_q;
	logic [TIME_W-1:0]  blink_count_q;
	logic               blink_phase_q;
	logic [TIME_W-1:0]  breathe_timer_q;
	logic [PCT_W-1:0]   breathe_level_q;
	logic               breathe_rising_q;

	// next state
	mode_t              mode_d;
	logic [LEVEL_W-1:0] level_d;
	logic [TIME_W-1:0]  key_age_d [NUM_KEYS];
	logic [NUM_KEYS-1:0] key_seen_d;
	logic [TIME_W-1:0]  beep_left_d;
	logic               buzzer_on_d;
	logic [TIME_W-1:0]  blink_count_d;
	logic               blink_phase_d;
	logic [TIME_W-1:0]  breathe_timer_d;
	logic [PCT_W-1:0]   breathe_level_d;
	logic               breathe_rising_d;
	logic [PCT_W-1:0]   percent_d;

	// pipeline
	logic v1_q, v2_q, v3_q, v4_q;
	logic free1, free2, free3, free4;
	cmd_t               cmd_s1;
	logic [PCT_W-1:0]   percent_s2;
	info_t              info_s2, info_s3;
	logic [PROD_W-1:0]  prod_s3;
	res_t               res_s4;

	logic [TIME_W:0]            period;
	logic [PROD_W+RECIP_W-1:0]  scaled;
	logic [TIME_W:0]            quot;

	assign free4 = !v4_q || !res_stall;
	assign free3 = !v3_q || free4;
	assign free2 = !v2_q || free3;
	assign free1 = !v1_q || free2;
	assign cmd_stall = !free1;
	assign res_valid = v4_q;
	assign res       = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q      <= 16'd999;
			debounce_q     <= 16'd150;
			beep_q         <= 16'd80;
			blink_half_q   <= 16'd500;
			breathe_step_q <= 16'd20;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PWM_TOP:      pwm_top_q      <= cfg_data;
				CFG_DEBOUNCE:     debounce_q     <= cfg_data;
				CFG_BEEP:         beep_q         <= cfg_data;
				CFG_BLINK_HALF:   blink_half_q   <= cfg_data;
				CFG_BREATHE_STEP: breathe_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// state update for the word in stage 1
	always_comb begin
		logic             hit;
		logic             ok;
		logic [PCT_W-1:0] target;
		mode_d           = mode_q;
		level_d          = level_q;
		key_age_d        = key_age_q;
		key_seen_d       = key_seen_q;
		beep_left_d      = beep_left_q;
		buzzer_on_d      = buzzer_on_q;
		blink_count_d    = blink_count_q;
		blink_phase_d    = blink_phase_q;
		breathe_timer_d  = breathe_timer_q;
		breathe_level_d  = breathe_level_q;
		breathe_rising_d = breathe_rising_q;
		hit = 1'b0;
		ok  = 1'b0;
		target = level_pct(level_q);

		if (cmd_s1.action == ACT_PRESS) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (int'(cmd_s1.key_id) == k) begin
					hit = 1'b1;
					ok  = !key_seen_q[k] || (key_age_q[k] >= debounce_q);
				end
			end
			// keys beyond the fitted count never hit and are dropped
			if (hit && ok) begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					if (int'(cmd_s1.key_id) == k) begin
						key_seen_d[k] = 1'b1;
						key_age_d[k]  = '0;
					end
				end
				beep_left_d = beep_q;
				buzzer_on_d = (beep_q != '0);
				if (cmd_s1.key_id == KEY_MODE) begin
					mode_d           = mode_t'(2'(mode_q + 2'd1));
					blink_count_d    = '0;
					blink_phase_d    = 1'b0;
					breathe_timer_d  = '0;
					breathe_level_d  = '0;
					breathe_rising_d = 1'b1;
				end else if (cmd_s1.key_id == KEY_BRIGHT) begin
					level_d = {1'b0, level_q[1:0]} + 3'd1;
				end
			end
		end else begin
			for (int k = 0; k < NUM_KEYS; k++)
				key_age_d[k] = sat_inc(key_age_q[k]);

			if (buzzer_on_q) begin
				beep_left_d = (beep_left_q != '0) ? beep_left_q - 16'd1 : '0;
				if (beep_left_d == '0)
					buzzer_on_d = 1'b0;
			end

			blink_count_d = sat_inc(blink_count_q);
			if (blink_count_d >= at_least_one(blink_half_q)) begin
				blink_count_d = '0;
				blink_phase_d = !blink_phase_q;
			end

			if (mode_q == MODE_BREATHE) begin
				breathe_timer_d = sat_inc(breathe_timer_q);
				if (breathe_timer_d >= at_least_one(breathe_step_q)) begin
					breathe_timer_d = '0;
					if (breathe_rising_q) begin
						if (breathe_level_q < target)
							breathe_level_d = breathe_level_q + 7'd1;
						else
							breathe_rising_d = 1'b0;
					end else if (breathe_level_q != '0) begin
						breathe_level_d = breathe_level_q - 7'd1;
					end else begin
						breathe_rising_d = 1'b1;
					end
				end
			end
		end

		case (mode_d)
			MODE_ON:      percent_d = level_pct(level_d);
			MODE_BLINK:   percent_d = blink_phase_d ? '0 : level_pct(level_d);
			MODE_BREATHE: percent_d = (breathe_level_d > PCT_FULL) ? PCT_FULL : breathe_level_d;
			default:      percent_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_ON;
			level_q          <= LEVEL_MAX;
			key_seen_q       <= '0;
			beep_left_q      <= '0;
			buzzer_on_q      <= 1'b0;
			blink_count_q    <= '0;
			blink_phase_q    <= 1'b0;
			breathe_timer_q  <= '0;
			breathe_level_q  <= '0;
			breathe_rising_q <= 1'b1;
			for (int k = 0; k < NUM_KEYS; k++)
				key_age_q[k] <= '0;
		end else if (v1_q && free2) begin
			mode_q           <= mode_d;
			level_q          <= level_d;
			key_seen_q       <= key_seen_d;
			beep_left_q      <= beep_left_d;
			buzzer_on_q      <= buzzer_on_d;
			blink_count_q    <= blink_count_d;
			blink_phase_q    <= blink_phase_d;
			breathe_timer_q  <= breathe_timer_d;
			breathe_level_q  <= breathe_level_d;
			breathe_rising_q <= breathe_rising_d;
			key_age_q        <= key_age_d;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (free1) v1_q <= cmd_valid;
			if (free2) v2_q <= v1_q;
			if (free3) v3_q <= v2_q;
			if (free4) v4_q <= v3_q;
		end
	end

	assign period = {1'b0, pwm_top_q} + 17'd1;
	assign scaled = (PROD_W+RECIP_W)'(prod_s3) * (PROD_W+RECIP_W)'(RECIP_100);
	assign quot   = scaled[RECIP_SHIFT +: TIME_W+1];

	// payload stages
	always_ff @(posedge clk) begin
		if (free1 && cmd_valid)
			cmd_s1 <= cmd;
		if (free2 && v1_q) begin
			percent_s2    <= percent_d;
			info_s2.buzz  <= buzzer_on_d;
			info_s2.mode  <= mode_d;
			info_s2.level <= level_d;
		end
		if (free3 && v2_q) begin
			prod_s3 <= PROD_W'(period) * PROD_W'(percent_s2);
			info_s3 <= info_s2;
		end
		if (free4 && v3_q) begin
			res_s4.led_compare    <= (quot > {1'b0, pwm_top_q}) ? pwm_top_q : quot[TIME_W-1:0];
			res_s4.buzzer_compare <= info_s3.buzz ? period[TIME_W:1] : '0;
			res_s4.lamp_mode      <= info_s3.mode;
			res_s4.bright_level   <= info_s3.level;
		end
	end

	// a stall is only raised with a word held at the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> v1_q)
		else $error("input stalled with empty input register");

	// a silent buzzer has no beep time left
	a_beep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!buzzer_on_q |-> (beep_left_q == '0))
		else $error("beep time left while buzzer off");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q != '0) && (level_q <= LEVEL_MAX))
		else $error("brightness level out of range");

	a_breathe_range: assert property (@(posedge clk) disable iff (!arst_n)
		breathe_level_q <= PCT_FULL)
		else $error("breathe level above full scale");

	// state only moves when a word leaves the input register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(v1_q && free2) |=> $stable(mode_q) && $stable(level_q))
		else $error("mode or level changed without a word");

endmodule

>>> tb/led_mode_pwm_controller_tb.sv
// Testbench for led_mode_pwm_controller: tick and key-press words go in, and each result
// word is checked against a behavioural model kept in a small scoreboard class.
// Depends on rtl/lmpc_pkg.sv and rtl/led_mode_pwm_controller.sv.
`timescale 1ns / 100ps

module led_mode_pwm_controller_tb;
	import lmpc_pkg::*;

	localparam int PIPE_LATENCY   = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS    = 150;
	localparam int LONG_TICKS     = 32;

	localparam logic [1:0] KEY_BEEP_LO = 2'd2;
	localparam logic [1:0] KEY_BEEP_HI = 2'd3;

	class pwm_scoreboard;
		logic [15:0] top, debounce, beep_len, blink_half, breathe_step;
		mode_t       mode;
		logic [2:0]  level;
		logic [15:0] age [NUM_KEYS];
		bit          seen [NUM_KEYS];
		logic [15:0] beep_left;
		bit          buzzing;
		logic [15:0] blink_cnt;
		bit          dark_half;
		logic [15:0] ramp_timer;
		logic [6:0]  ramp_pct;
		bit          ramp_up;
		res_t        outputs_due [$];
		int          errors;

		function new();
			top          = 16'd999;
			debounce     = 16'd150;
			beep_len     = 16'd80;
			blink_half   = 16'd500;
			breathe_step = 16'd20;
			mode         = MODE_ON;
			level        = 3'd4;
			for (int k = 0; k < NUM_KEYS; k++) begin
				age[k]  = '0;
				seen[k] = 1'b0;
			end
			beep_left = '0;
			buzzing   = 1'b0;
			restart_timing();
			errors = 0;
		endfunction

		function void restart_timing();
			blink_cnt  = '0;
			dark_half  = 1'b0;
			ramp_timer = '0;
			ramp_pct   = '0;
			ramp_up    = 1'b1;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				CFG_PWM_TOP:      top = val;
				CFG_DEBOUNCE:     debounce = val;
				CFG_BEEP:         beep_len = val;
				CFG_BLINK_HALF:   blink_half = val;
				CFG_BREATHE_STEP: breathe_step = val;
				default: ;
			endcase
		endfunction

		function int unsigned level_percent();
			case (level)
				3'd1:    return 25;
				3'd2:    return 50;
				3'd3:    return 75;
				default: return 100;
			endcase
		endfunction

		function void tick();
			for (int k = 0; k < NUM_KEYS; k++)
				if (age[k] != 16'hFFFF) age[k] = age[k] + 16'd1;
			if (buzzing) begin
				if (beep_left != 0) beep_left = beep_left - 16'd1;
				if (beep_left == 0) buzzing = 1'b0;
			end
			if (blink_cnt != 16'hFFFF) blink_cnt = blink_cnt + 16'd1;
			// a zero half period behaves as one tick
			if (blink_cnt >= ((blink_half == 0) ? 16'd1 : blink_half)) begin
				blink_cnt = '0;
				dark_half = !dark_half;
			end
			if (mode == MODE_BREATHE) begin
				if (ramp_timer != 16'hFFFF) ramp_timer = ramp_timer + 16'd1;
				if (ramp_timer >= ((breathe_step == 0) ? 16'd1 : breathe_step)) begin
					ramp_timer = '0;
					if (ramp_up) begin
						if (ramp_pct < level_percent()) ramp_pct = ramp_pct + 7'd1;
						else ramp_up = 1'b0;
					end else if (ramp_pct > 0) begin
						ramp_pct = ramp_pct - 7'd1;
					end else begin
						ramp_up = 1'b1;
					end
				end
			end
		endfunction

		function void press(logic [1:0] key);
			if (int'(key) >= NUM_KEYS) return;
			if (seen[key] && age[key] < debounce) return;
			seen[key] = 1'b1;
			age[key]  = '0;
			beep_left = beep_len;
			buzzing   = (beep_len != 0);
			if (key == KEY_MODE) begin
				mode = mode_t'(2'(mode + 2'd1));
				restart_timing();
			end else if (key == KEY_BRIGHT) begin
				level = (level == LEVEL_MAX) ? 3'd1 : level + 3'd1;
			end
		endfunction

		// advance the model by one accepted word and queue the word it should produce
		function void note_word(cmd_t w);
			int unsigned pct, period, cmp;
			res_t        want;
			if (w.action == ACT_PRESS) press(w.key_id);
			else tick();
			case (mode)
				MODE_ON:      pct = level_percent();
				MODE_BLINK:   pct = dark_half ? 0 : level_percent();
				MODE_BREATHE: pct = (ramp_pct > 100) ? 100 : ramp_pct;
				default:      pct = 0;
			endcase
			period = 32'(top) + 32'd1;
			cmp = (period * pct) / 100;
			if (cmp > top) cmp = top;
			want.led_compare    = cmp[15:0];
			want.buzzer_compare = buzzing ? 16'(period / 2) : 16'd0;
			want.lamp_mode      = mode;
			want.bright_level   = level;
			outputs_due.push_back(want);
		endfunction

		function void check_word(res_t got);
			res_t want;
			if (outputs_due.size() == 0) begin
				$error("result word with nothing expected: %p", got);
				errors++;
				return;
			end
			want = outputs_due.pop_front();
			if (got.led_compare !== want.led_compare) begin
				$error("led_compare expected %0d actual %0d", want.led_compare, got.led_compare);
				errors++;
			end
			if (got.buzzer_compare !== want.buzzer_compare) begin
				$error("buzzer_compare expected %0d actual %0d",
					want.buzzer_compare, got.buzzer_compare);
				errors++;
			end
			if (got.lamp_mode !== want.lamp_mode) begin
				$error("lamp_mode expected %0d actual %0d", want.lamp_mode, got.lamp_mode);
				errors++;
			end
			if (got.bright_level !== want.bright_level) begin
				$error("bright_level expected %0d actual %0d",
					want.bright_level, got.bright_level);
				errors++;
			end
		endfunction

		function int pending();
			return outputs_due.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_t                 cmd;
	logic                 res_valid;
	logic                 res_stall;
	res_t                 res;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	pwm_scoreboard sb;
	bit            idling = 1'b1;
	bit            hold_request = 1'b0;
	int            hold_left = 0;
	int            quiet_cycles = 0;

	led_mode_pwm_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_word(input logic act, input logic [1:0] key);
		cmd_t w;
		w.action = act;
		w.key_id = key;
		while (idling && $urandom_range(99) < 19) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_word(w);
	endtask

	// stop offering words until every queued result has come out
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic program_regs(input logic [15:0] top, input logic [15:0] deb,
			input logic [15:0] beep, input logic [15:0] blink, input logic [15:0] breathe);
		write_reg(CFG_PWM_TOP, top);
		write_reg(CFG_DEBOUNCE, deb);
		write_reg(CFG_BEEP, beep);
		write_reg(CFG_BLINK_HALF, blink);
		write_reg(CFG_BREATHE_STEP, breathe);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [1:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) return KEY_MODE;
		if (r < 40) return KEY_BRIGHT;
		return 2'($urandom_range(2, 3));
	endfunction

	initial begin : receiver
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= idling && ($urandom_range(99) < 19);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_word(res);
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("led_mode_pwm_controller_tb: errors");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned press_pct;
		logic [15:0] top;

		sb = new();
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_PWM_TOP;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first presses, debounce rejection, every key
		send_word(ACT_TICK, 2'd0);
		send_word(ACT_PRESS, KEY_MODE);
		send_word(ACT_PRESS, KEY_MODE);
		send_word(ACT_PRESS, KEY_BRIGHT);
		send_word(ACT_PRESS, KEY_BEEP_LO);
		send_word(ACT_PRESS, KEY_BEEP_HI);
		send_word(ACT_TICK, 2'd3);
		settle();

		// full-scale top, zero debounce, zero beep, zero blink and breathe times
		program_regs(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
		send_word(ACT_PRESS, KEY_MODE);
		send_word(ACT_PRESS, KEY_MODE);
		repeat (4) send_word(ACT_TICK, 2'd0);
		send_word(ACT_PRESS, KEY_MODE);
		send_word(ACT_PRESS, KEY_MODE);
		repeat (4) send_word(ACT_PRESS, KEY_BRIGHT);
		send_word(ACT_PRESS, KEY_BEEP_LO);
		repeat (2) send_word(ACT_TICK, 2'd1);
		send_word(ACT_PRESS, KEY_MODE);
		send_word(ACT_PRESS, KEY_MODE);
		repeat (2) send_word(ACT_TICK, 2'd2);
		settle();

		for (int k = 0; k < 6; k++) begin
			idling = (k != 0);
			case (k % 4)
				0:       top = 16'd0;
				1:       top = 16'hFFFF;
				2:       top = 16'($urandom_range(1, 65534));
				default: top = 16'($urandom_range(0, 300));
			endcase
			program_regs(top, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 15)),
				16'($urandom_range(0, 9)), 16'($urandom_range(0, 4)));
			press_pct = $urandom_range(5, 35);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (k == 2 && n == 50) hold_request = 1'b1;
				if (k == 3 && n == 75) settle();
				if ($urandom_range(99) < press_pct)
					send_word(ACT_PRESS, pick_key());
				else
					send_word(ACT_TICK, 2'($urandom_range(3)));
			end
			settle();
		end

		// step into breathe, then a stretch with every register at full scale
		program_regs(16'd999, 16'd0, 16'd3, 16'd2, 16'd1);
		while (sb.mode != MODE_BREATHE) send_word(ACT_PRESS, KEY_MODE);
		repeat (8) send_word(ACT_TICK, 2'($urandom_range(3)));
		settle();
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (int n = 0; n < LONG_TICKS; n++) begin
			if (n % 8 == 7)
				send_word(ACT_PRESS, 2'($urandom_range(1, 3)));
			else
				send_word(ACT_TICK, 2'($urandom_range(3)));
		end
		send_word(ACT_PRESS, KEY_BRIGHT);
		send_word(ACT_PRESS, KEY_BEEP_LO);
		send_word(ACT_PRESS, KEY_BEEP_HI);
		settle();

		if (sb.errors == 0)
			$display("led_mode_pwm_controller_tb: clean");
		else
			$display("led_mode_pwm_controller_tb: errors");
		$finish;
	end

endmodule
